FILE: rtl/core/sha256_pkg.sv
// shared types, constants and round functions for the sha-256 hasher
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TotalW = 61;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned RoundW = 6;

  typedef logic [WordW-1:0] word_t;

  // request function codes
  typedef enum logic {
    FN_ABSORB = 1'b0,
    FN_FINISH = 1'b1
  } hash_fn_e;

  localparam logic [ByteW-1:0] PadMark = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic       load_byte;   // shift data byte into block, count it
    logic       mark_write;  // shift in the 0x80 marker, set up padding
    logic       pad_write;   // shift in one padding byte at the pad pointer
    logic       comp_start;  // load working vars from the chain
    logic       comp_round;  // run one round
    logic       comp_add;    // fold working vars into the chain
    logic       out_shift;   // step digest output
    logic       restart;     // chain back to initial values, count to zero
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       round_last;
    logic       pad_block_end;  // pad pointer at the final byte of a block
    logic       pad_needs_extra;
    logic       block_full;     // next byte completes a block
  } dp_stat_t;

  localparam word_t InitH [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: rtl/core/sha256_if.sv
// request and digest channel interfaces
interface sha256_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface sha256_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/core/sha256_ctrl.sv
// controller state machine: absorb, pad, compress and digest output
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_func_i,
  output logic     req_ready_o,
  output logic     dig_valid_o,
  input  logic     dig_ready_i,
  input  logic     out_last_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        final_q, final_d;  // compression in flight is the closing one
  logic        req_fire;
  logic        is_finish;

  assign req_fire  = req_valid_i && req_ready_o;
  assign is_finish = (req_func_i == FN_FINISH);

  always_comb begin
    state_d = state_q;
    final_d = final_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (stat_i.block_full) begin
            // data byte or marker closes the block
            state_d = ST_COMP;
            final_d = 1'b0;
          end else if (is_finish) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (stat_i.pad_block_end) begin
          state_d = ST_COMP;
          final_d = !stat_i.pad_needs_extra;
        end
      end
      ST_COMP: begin
        if (stat_i.round_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_q) begin
          state_d = ST_OUT;
        end else if (stat_i.pad_needs_extra) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (dig_ready_i && out_last_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    dig_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o      = 1'b1;
        cmd_o.load_byte  = req_fire && !is_finish;
        cmd_o.mark_write = req_fire && is_finish;
        cmd_o.comp_start = req_fire && stat_i.block_full;
      end
      ST_PAD: begin
        cmd_o.pad_write  = 1'b1;
        cmd_o.comp_start = stat_i.pad_block_end;
      end
      ST_COMP: cmd_o.comp_round = 1'b1;
      ST_ADD: begin
        cmd_o.comp_add = 1'b1;
      end
      ST_OUT: begin
        dig_valid_o     = 1'b1;
        cmd_o.out_shift = dig_ready_i;
        cmd_o.restart   = dig_ready_i && out_last_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

endmodule

FILE: rtl/core/sha256_dp.sv
// datapath: block shift register, padding, round unit and chain
module sha256_dp
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  data_byte_i,
  output dp_stat_t    stat_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  logic [TotalW-1:0] total_q;
  logic [5:0]        pad_ptr_q;
  logic              extra_q;      // block being padded is not the closing one
  word_t             w_q [16];     // block bytes while filling, schedule during rounds
  word_t             v_q [8];
  word_t             h_q [8];
  logic [RoundW-1:0] rnd_q;
  logic [2:0]        oidx_q;
  logic [63:0]       bits;
  logic [5:0]        used;
  logic [ByteW-1:0]  pad_byte;
  logic [ByteW-1:0]  in_byte;
  logic              shift_en;
  word_t             w_new, t1, t2;

  assign used = total_q[5:0];
  assign bits = {total_q, 3'b000};

  // padding byte at the pad pointer: zeros, then the length in the closing block
  always_comb begin
    if (!extra_q && pad_ptr_q >= 6'd56) begin
      pad_byte = bits[{~pad_ptr_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    if (cmd_i.load_byte) begin
      in_byte = data_byte_i;
    end else if (cmd_i.mark_write) begin
      in_byte = PadMark;
    end else begin
      in_byte = pad_byte;
    end
  end

  assign shift_en = cmd_i.load_byte || cmd_i.mark_write || cmd_i.pad_write;

  assign stat_o.pad_block_end   = (pad_ptr_q == 6'd63);
  assign stat_o.pad_needs_extra = extra_q;
  assign stat_o.block_full      = (used == 6'd63);
  assign stat_o.round_last      = (rnd_q == RoundW'(NumRounds - 1));

  assign w_new = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_q[0];
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      // bytes enter at the bottom, first byte ends up in the top of word 0
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_q[15] <= {w_q[15][23:0], in_byte};
    end else if (cmd_i.comp_round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (cmd_i.comp_round) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      pad_ptr_q <= '0;
      extra_q   <= 1'b0;
      rnd_q     <= '0;
      oidx_q    <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= InitH[i];
      end
    end else begin
      if (cmd_i.load_byte) begin
        total_q <= total_q + TotalW'(1);
      end
      if (cmd_i.mark_write) begin
        pad_ptr_q <= used + 6'd1;
        extra_q   <= (used >= 6'd56);
      end else if (cmd_i.pad_write) begin
        pad_ptr_q <= pad_ptr_q + 6'd1;
      end
      if (cmd_i.comp_start) begin
        rnd_q <= '0;
      end else if (cmd_i.comp_round) begin
        rnd_q <= rnd_q + RoundW'(1);
      end
      if (cmd_i.comp_add) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
        // second padding block follows: zeros then the length
        if (extra_q) begin
          extra_q <= 1'b0;
        end
      end
      if (cmd_i.out_shift) begin
        oidx_q <= oidx_q + 3'd1;
      end
      if (cmd_i.restart) begin
        total_q <= '0;
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= InitH[i];
        end
      end
    end
  end

  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

endmodule

FILE: rtl/core/sha256_message_hasher_top.sv
// top level of the streaming sha-256 hasher
//
//  channel | dir | payload                               | handshake
//  req     | in  | func, data_byte                       | valid/ready
//  dig     | out | digest_word, word_index, last_word    | valid/ready
//
// an absorb request is taken while idle; the byte that completes a block holds the
// next request off during compression (64 rounds on one round unit, one chain add).
// a finish request pads one byte per cycle to the end of the block, then compresses
// it; more than 55 pending bytes add a second block that is padded and compressed.
// eight digest words follow, one per accepted cycle; requests stall until idle.
// reset is asynchronous; every block is filled completely before it is compressed.
module sha256_message_hasher_top
  import sha256_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha256_req_if.sink   req,
  sha256_dig_if.source dig
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     last_word;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_func_i  (req.func),
    .req_ready_o (req.ready),
    .dig_valid_o (dig.valid),
    .dig_ready_i (dig.ready),
    .out_last_i  (last_word),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (req.data_byte),
    .stat_o        (stat),
    .digest_word_o (dig.digest_word),
    .word_index_o  (dig.word_index),
    .last_word_o   (last_word)
  );

  assign dig.last_word = last_word;

`ifndef SYNTHESIS
  a_no_req_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig.valid |-> !req.ready) else $error("request taken while digest pending");
  a_last_ends_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig.valid && dig.ready && last_word) |=> !dig.valid)
    else $error("digest continues past last word");
  a_last_at_seven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig.valid |-> (last_word == (dig.word_index == 3'd7)))
    else $error("last word flag out of step with index");
`endif

endmodule
